// File: design/pcicfg_pkg.sv
// constants and helper functions for the two-function pci configuration space
// no dependencies; imported by pci_config_space_southbridge
`timescale 1ns / 1ps

package pcicfg_pkg;

  localparam logic       REQ_READ    = 1'b0;
  localparam logic       REQ_WRITE   = 1'b1;
  localparam logic [2:0] FUNC_BRIDGE = 3'd0;
  localparam logic [2:0] FUNC_IDE    = 3'd1;

  localparam logic [7:0] ABSENT_DATA = 8'hFF;

  // register offsets with side effects
  localparam logic [7:0] ADDR_CMD      = 8'h04;
  localparam logic [7:0] ADDR_BM_BASE0 = 8'h20;
  localparam logic [7:0] ADDR_BM_BASE1 = 8'h21;
  localparam logic [7:0] ADDR_DMA_CTL  = 8'h4C;
  localparam logic [7:0] ADDR_MOUSE    = 8'h4E;
  localparam logic [5:0] ADDR_PIRQ_HI  = 6'b011000;
  localparam logic [5:0] ADDR_BM_HI    = 6'b001000;

  localparam logic [4:0] IRQ_DISABLED  = 5'd16;

  function automatic logic [7:0] bridge_reset_val(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r = 8'h86;
      8'h01: r = 8'h80;
      8'h02: r = 8'h10;
      8'h03: r = 8'h71;
      8'h04: r = 8'h07;
      8'h06: r = 8'h80;
      8'h07: r = 8'h02;
      8'h0A: r = 8'h01;
      8'h0B: r = 8'h06;
      8'h0E: r = 8'h80;
      8'h4C: r = 8'h4D;
      8'h4E: r = 8'h03;
      8'h60, 8'h61, 8'h62, 8'h63: r = 8'h80;
      8'h64: r = 8'h10;
      8'h69: r = 8'h02;
      8'h76, 8'h77: r = 8'h04;
      8'hCB: r = 8'h21;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic bridge_protected(input logic [7:0] a);
    return (a <= 8'h03) || (a >= 8'h08 && a <= 8'h0B) || (a >= 8'h0E && a <= 8'h4B);
  endfunction

  function automatic logic [7:0] bridge_read_filter(input logic [7:0] a, input logic [7:0] r,
                                                    input logic mouse);
    logic [7:0] d;
    if (a[7:2] == ADDR_PIRQ_HI) begin
      d = r & 8'h8F;
    end else begin
      case (a)
        8'h04: d = (r & 8'h08) | 8'h07;
        8'h05: d = r & 8'h01;
        8'h06: d = 8'h80;
        8'h07: d = (r & 8'h78) | 8'h02;
        8'h4E: d = (r & 8'hEF) | {7'd0, mouse};
        8'h4F: d = r & 8'h06;
        8'h69: d = r & 8'hFE;
        8'h6A, 8'h6B: d = r & 8'h80;
        8'h76, 8'h77: d = (r & 8'h87) | 8'h08;
        8'h80: d = r & 8'h7F;
        8'h82: d = r & 8'h0F;
        8'h91: d = r & 8'hFC;
        8'h92, 8'h94: d = r & 8'hC0;
        8'hB0: d = r & 8'h7F;
        8'hB1: d = r & 8'hDF;
        8'hB3: d = r & 8'hFD;
        8'hCB: d = r & 8'h3D;
        default: d = r;
      endcase
    end
    return d;
  endfunction

  // fixed bytes of the ide function at offsets that never store
  function automatic logic [7:0] ide_const_val(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r = 8'h86;
      8'h01: r = 8'h80;
      8'h02: r = 8'h11;
      8'h03: r = 8'h71;
      8'h06: r = 8'h80;
      8'h09: r = 8'h80;
      8'h0A: r = 8'h01;
      8'h0B: r = 8'h01;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// File: design/pci_config_space_southbridge.sv
// two-function pci configuration space: isa bridge (function 0) and ide (function 1)
// depends on pcicfg_pkg
//
// channel   direction  handshake              payload
// request   in         req_valid / req_stall  req_type func_num reg_addr write_data mouse_scan_in
// response  out        rsp_valid / rsp_stall  read_data irq_* ide_* bus_master_* dma_* mouse_*
//
// one transfer per cycle while rsp_stall is low; request stage, then response register
// the bridge byte store is read and written at request time, the response register follows
// bridge store entries carry valid bits cleared by reset, so no clearing pass is needed
// rst is synchronous and active high; a stalled response holds the stage behind it
`timescale 1ns / 1ps

module pci_config_space_southbridge
  import pcicfg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        req_type,
  input  logic [2:0]  func_num,
  input  logic [7:0]  reg_addr,
  input  logic [7:0]  write_data,
  input  logic        mouse_scan_in,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [7:0]  read_data,
  output logic        irq_route_update,
  output logic [1:0]  irq_route_line,
  output logic [4:0]  irq_route_irq,
  output logic        ide_primary_on,
  output logic        ide_secondary_on,
  output logic        bus_master_update,
  output logic        bus_master_on,
  output logic [15:0] bus_master_base,
  output logic        dma_alias_on,
  output logic        mouse_scan_update,
  output logic        mouse_scan_value
);

  logic         rsp_ready;
  logic         s1_ready;
  logic         req_acc;
  logic         bridge_we;
  logic         ide_we;

  logic         s1_valid;
  logic         s1_type;
  logic [2:0]   s1_func;
  logic [7:0]   s1_addr;
  logic [7:0]   s1_data;
  logic         s1_mouse;
  logic [7:0]   s1_mem;
  logic         s1_hit;

  logic [7:0]   bridge_mem [256];
  logic [255:0] bridge_vld;
  logic         dma_ctl7;

  logic [7:0]   ide_cmd;
  logic [7:0]   ide_stat_hi;
  logic [7:0]   ide_0d;
  logic [7:0]   ide_20;
  logic [7:0]   ide_21;
  logic [7:0]   ide_40;
  logic [7:0]   ide_41;
  logic [7:0]   ide_42;
  logic [7:0]   ide_43;
  logic [7:0]   ide_44;
  logic [7:0]   ide_48;
  logic [7:0]   ide_4a;
  logic [7:0]   ide_4b;

  logic [7:0]   bridge_raw;
  logic [7:0]   bridge_rd;
  logic [7:0]   ide_raw;
  logic [7:0]   ide_rd;
  logic [7:0]   read_data_next;
  logic         s1_bridge_wr;
  logic         s1_ide_wr;
  logic         irq_route_update_next;
  logic [4:0]   irq_route_irq_next;
  logic         bus_master_update_next;
  logic         mouse_scan_update_next;

  assign rsp_ready = !rsp_valid || !rsp_stall;
  assign s1_ready  = !s1_valid || rsp_ready;
  assign req_stall = s1_valid && !rsp_ready;
  assign req_acc   = req_valid && s1_ready;
  assign bridge_we = req_acc && (req_type == REQ_WRITE) && (func_num == FUNC_BRIDGE) &&
                     !bridge_protected(reg_addr);
  assign ide_we    = req_acc && (req_type == REQ_WRITE) && (func_num == FUNC_IDE);

  // request stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      s1_type  <= req_type;
      s1_func  <= func_num;
      s1_addr  <= reg_addr;
      s1_data  <= write_data;
      s1_mouse <= mouse_scan_in;
      s1_hit   <= bridge_vld[reg_addr];
    end
  end

  // bridge byte store
  always_ff @(posedge clk) begin
    if (req_acc) begin
      s1_mem <= bridge_mem[reg_addr];
    end
    if (bridge_we) begin
      bridge_mem[reg_addr] <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bridge_vld <= '0;
      dma_ctl7   <= 1'b0;
    end else if (bridge_we) begin
      bridge_vld[reg_addr] <= 1'b1;
      if (reg_addr == ADDR_DMA_CTL) begin
        dma_ctl7 <= write_data[7];
      end
    end
  end

  // ide registers that take writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ide_cmd     <= 8'h07;
      ide_stat_hi <= 8'h02;
      ide_0d      <= 8'h00;
      ide_20      <= 8'h01;
      ide_21      <= 8'h00;
      ide_40      <= 8'h00;
      ide_41      <= 8'h80;
      ide_42      <= 8'h00;
      ide_43      <= 8'h80;
      ide_44      <= 8'h00;
      ide_48      <= 8'h00;
      ide_4a      <= 8'h00;
      ide_4b      <= 8'h00;
    end else if (ide_we) begin
      case (reg_addr)
        8'h04: ide_cmd     <= (write_data & 8'h05) | 8'h02;
        8'h07: ide_stat_hi <= write_data & 8'h3E;
        8'h0D: ide_0d      <= write_data;
        8'h20: ide_20      <= (write_data & 8'hF0) | 8'h01;
        8'h21: ide_21      <= write_data;
        8'h40: ide_40      <= write_data;
        8'h41: ide_41      <= write_data;
        8'h42: ide_42      <= write_data;
        8'h43: ide_43      <= write_data;
        8'h44: ide_44      <= write_data;
        8'h48: ide_48      <= write_data;
        8'h4A: ide_4a      <= write_data;
        8'h4B: ide_4b      <= write_data;
        default: ;
      endcase
    end
  end

  // read paths
  always_comb begin
    bridge_raw = s1_hit ? s1_mem : bridge_reset_val(s1_addr);
    bridge_rd  = bridge_read_filter(s1_addr, bridge_raw, s1_mouse);
  end

  always_comb begin
    case (s1_addr)
      8'h04: ide_raw = ide_cmd;
      8'h07: ide_raw = ide_stat_hi;
      8'h0D: ide_raw = ide_0d;
      8'h20: ide_raw = ide_20;
      8'h21: ide_raw = ide_21;
      8'h40: ide_raw = ide_40;
      8'h41: ide_raw = ide_41;
      8'h42: ide_raw = ide_42;
      8'h43: ide_raw = ide_43;
      8'h44: ide_raw = ide_44;
      8'h48: ide_raw = ide_48;
      8'h4A: ide_raw = ide_4a;
      8'h4B: ide_raw = ide_4b;
      default: ide_raw = ide_const_val(s1_addr);
    endcase
    case (s1_addr)
      8'h04: ide_rd = ide_raw & 8'h05;
      8'h05: ide_rd = 8'h00;
      8'h06: ide_rd = 8'h80;
      8'h07: ide_rd = ide_raw & 8'h3E;
      8'h0D: ide_rd = ide_raw & 8'hF0;
      8'h20: ide_rd = (ide_raw & 8'hF0) | 8'h01;
      8'h22, 8'h23: ide_rd = 8'h00;
      8'h41, 8'h43: ide_rd = ide_raw & 8'hF3;
      8'h48: ide_rd = ide_raw & 8'h0F;
      8'h4A, 8'h4B: ide_rd = ide_raw & 8'h33;
      default: ide_rd = ide_raw;
    endcase
  end

  always_comb begin
    if (s1_type == REQ_WRITE) begin
      read_data_next = 8'h00;
    end else if (s1_func == FUNC_BRIDGE) begin
      read_data_next = bridge_rd;
    end else if (s1_func == FUNC_IDE) begin
      read_data_next = ide_rd;
    end else begin
      read_data_next = ABSENT_DATA;
    end
    s1_bridge_wr = (s1_type == REQ_WRITE) && (s1_func == FUNC_BRIDGE) &&
                   !bridge_protected(s1_addr);
    s1_ide_wr    = (s1_type == REQ_WRITE) && (s1_func == FUNC_IDE);
    irq_route_update_next  = s1_bridge_wr && (s1_addr[7:2] == ADDR_PIRQ_HI);
    irq_route_irq_next     = s1_data[7] ? IRQ_DISABLED : {1'b0, s1_data[3:0]};
    mouse_scan_update_next = s1_bridge_wr && (s1_addr == ADDR_MOUSE);
    bus_master_update_next = s1_ide_wr &&
                             ((s1_addr == ADDR_CMD) || (s1_addr[7:2] == ADDR_BM_HI));
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_ready) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_ready && s1_valid) begin
      read_data         <= read_data_next;
      irq_route_update  <= irq_route_update_next;
      irq_route_line    <= irq_route_update_next ? s1_addr[1:0] : 2'd0;
      irq_route_irq     <= irq_route_update_next ? irq_route_irq_next : 5'd0;
      ide_primary_on    <= ide_41[7];
      ide_secondary_on  <= ide_43[7];
      bus_master_update <= bus_master_update_next;
      bus_master_on     <= ide_cmd[0];
      bus_master_base   <= {ide_21, ide_20[7:4], 4'h0};
      dma_alias_on      <= !dma_ctl7;
      mouse_scan_update <= mouse_scan_update_next;
      mouse_scan_value  <= mouse_scan_update_next ? s1_data[4] : 1'b0;
    end
  end

`ifndef SYNTH
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid && rsp_valid)
    else $error("request stalled with no item ahead");

  a_write_reads_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (irq_route_update || bus_master_update || mouse_scan_update)
      |-> read_data == 8'h00)
    else $error("write response carries read data");

  a_one_bridge_effect: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(irq_route_update && mouse_scan_update))
    else $error("two bridge side effects on one write");

  a_bm_base_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> bus_master_base[3:0] == 4'h0)
    else $error("bus-master base not 16-byte aligned");

  a_ide_side_effect_func: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && bus_master_update |-> !irq_route_update && !mouse_scan_update)
    else $error("ide and bridge side effects together");
`endif

endmodule
